>>> rtl/core/bsim_pkg.sv
// Shared types, register addresses and constants for the bank switch scanline IRQ mapper.
package bsim_pkg;

    localparam int AddrW  = 16;
    localparam int DataW  = 8;
    localparam int CountW = 16;
    localparam int SlotW  = 4;

    // word kind on the input side
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // configuration register index
    typedef enum logic {
        CFG_ALT_MODE  = 1'b0,
        CFG_TICK_STEP = 1'b1
    } cfg_idx_t;

    // bank select addresses (both layouts)
    localparam logic [AddrW-1:0] ADDR_PRG0     = 16'h8000;
    localparam logic [AddrW-1:0] ADDR_PRG1     = 16'hA000;
    localparam logic [AddrW-1:0] ADDR_PRG2     = 16'hC000;
    localparam logic [AddrW-1:0] ADDR_CHR_BASE = 16'hB000;

    // normal layout
    localparam logic [AddrW-1:0] ADDR_MIRROR    = 16'h9000;
    localparam logic [AddrW-1:0] ADDR_IRQ_EN    = 16'h9003;
    localparam logic [AddrW-1:0] ADDR_IRQ_LOAD  = 16'h9004;
    localparam logic [AddrW-1:0] ADDR_RELOAD_HI = 16'h9005;
    localparam logic [AddrW-1:0] ADDR_RELOAD_LO = 16'h9006;

    // alternate layout
    localparam logic [AddrW-1:0] ADDR_ALT_MIRROR = 16'h9001;
    localparam logic [AddrW-1:0] ADDR_ALT_COUNT  = 16'h9005;
    localparam logic [AddrW-1:0] ADDR_ALT_ENABLE = 16'h9006;

    localparam logic [SlotW-1:0] SLOT_PRG0     = 4'd0;
    localparam logic [SlotW-1:0] SLOT_PRG1     = 4'd1;
    localparam logic [SlotW-1:0] SLOT_PRG2     = 4'd2;
    localparam logic [SlotW-1:0] SLOT_CHR_BASE = 4'd3;
    localparam logic [SlotW-1:0] SLOT_LAST     = 4'd10;

    localparam logic [CountW-1:0] COUNT_FULL      = 16'hFFFF;
    localparam logic [CountW-1:0] TICK_STEP_RESET = 16'd113;

    localparam int DataBitVert = 6;   // normal layout mirroring bit
    localparam int DataBitHorz = 7;   // alternate layout mirroring bit
    localparam int DataBitIrq  = 7;   // normal layout enable bit

    typedef struct packed {
        op_t              opcode;
        logic [AddrW-1:0] address;
        logic [DataW-1:0] wr_data;
    } item_t;

    typedef struct packed {
        logic             irq_fire;
        logic             bank_valid;
        logic [SlotW-1:0] bank_slot;
        logic [DataW-1:0] bank_value;
        logic             mirror_valid;
        logic             mirror_vertical;
    } result_t;

endpackage

>>> rtl/core/bsim_core.sv
// Mapper register decode and scanline IRQ counter state.
module bsim_core import bsim_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,       // commit this word's state update
    input  item_t             item,
    input  logic              alt_mode,
    input  logic [CountW-1:0] tick_step,
    output result_t           result
);

    logic              irq_on_reg,     irq_on_next;
    logic [CountW-1:0] irq_count_reg,  irq_count_next;
    logic [CountW-1:0] irq_reload_reg, irq_reload_next;
    logic              chr_hit;

    assign chr_hit = (item.address[AddrW-1:3] == ADDR_CHR_BASE[AddrW-1:3]);

    always_comb begin
        result          = '0;
        irq_on_next     = irq_on_reg;
        irq_count_next  = irq_count_reg;
        irq_reload_next = irq_reload_reg;

        if (item.opcode == OP_TICK) begin
            if (irq_on_reg) begin
                if (alt_mode) begin
                    if (irq_count_reg == '0) begin
                        result.irq_fire = 1'b1;
                        irq_on_next     = 1'b0;
                    end else begin
                        irq_count_next = irq_count_reg - CountW'(1);
                    end
                end else if (irq_count_reg <= tick_step) begin
                    result.irq_fire = 1'b1;
                    irq_on_next     = 1'b0;
                    irq_count_next  = COUNT_FULL;
                end else begin
                    irq_count_next = irq_count_reg - tick_step;
                end
            end
        end else begin
            priority if (item.address == ADDR_PRG0) begin
                result.bank_valid = 1'b1;
                result.bank_slot  = SLOT_PRG0;
                result.bank_value = item.wr_data;
            end else if (item.address == ADDR_PRG1) begin
                result.bank_valid = 1'b1;
                result.bank_slot  = SLOT_PRG1;
                result.bank_value = item.wr_data;
            end else if (item.address == ADDR_PRG2) begin
                result.bank_valid = 1'b1;
                result.bank_slot  = SLOT_PRG2;
                result.bank_value = item.wr_data;
            end else if (chr_hit) begin
                result.bank_valid = 1'b1;
                result.bank_slot  = SLOT_CHR_BASE + {1'b0, item.address[2:0]};
                result.bank_value = item.wr_data;
            end else if (alt_mode) begin
                unique case (item.address)
                    ADDR_ALT_MIRROR: begin
                        result.mirror_valid    = 1'b1;
                        result.mirror_vertical = ~item.wr_data[DataBitHorz];
                    end
                    ADDR_ALT_COUNT: begin
                        // count = (data << 1) mod 256
                        irq_count_next = {{(CountW-DataW){1'b0}},
                                          item.wr_data[DataW-2:0], 1'b0};
                        irq_on_next    = (item.wr_data != '0);
                    end
                    ADDR_ALT_ENABLE: irq_on_next = 1'b1;
                    default: ;
                endcase
            end else begin
                unique case (item.address)
                    ADDR_MIRROR: begin
                        result.mirror_valid    = 1'b1;
                        result.mirror_vertical = item.wr_data[DataBitVert];
                    end
                    ADDR_IRQ_EN:    irq_on_next = item.wr_data[DataBitIrq];
                    ADDR_IRQ_LOAD:  irq_count_next = irq_reload_reg;
                    ADDR_RELOAD_HI: irq_reload_next = {item.wr_data,
                                                       irq_reload_reg[DataW-1:0]};
                    ADDR_RELOAD_LO: irq_reload_next = {irq_reload_reg[CountW-1:DataW],
                                                       item.wr_data};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_on_reg     <= 1'b0;
            irq_count_reg  <= '0;
            irq_reload_reg <= '0;
        end else if (step) begin
            irq_on_reg     <= irq_on_next;
            irq_count_reg  <= irq_count_next;
            irq_reload_reg <= irq_reload_next;
        end
    end

endmodule

>>> rtl/core/bank_switch_scanline_irq_mapper_top.sv
// Top level of the bank switch scanline IRQ mapper: stream ports, config and pipeline.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  s_       | in        | s_tvalid / s_tready   | tdata: address, wr_data; tuser: opcode
//  m_       | out       | m_tvalid / m_tready   | tdata: irq_fire, slot, value, vertical;
//           |           |                       | tuser: bank_valid, mirror_valid
//  cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word per cycle sustained while m_tready is high; each word gives exactly one result
//  word, through the input register, then decode/counter update into the result register.
//  The counter state is committed in the cycle the word leaves the input register, so the
//  next word always sees it.
//  aresetn is synchronous: clears both valid flags, the IRQ state, and sets the config
//  registers to alt_mode = 0, tick_step = 113.
//  A stall on m_tready holds the result register; the input register keeps accepting
//  until it is also full. cfg_ready is always high.
module bank_switch_scanline_irq_mapper_top import bsim_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,    // [15:0] address, [23:16] wr_data
    input  logic              s_tuser,    // [0] opcode

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,    // [0] irq_fire, [4:1] bank_slot,
                                          // [12:5] bank_value, [13] mirror_vertical, 0 above
    output logic [1:0]        m_tuser,    // [0] bank_valid, [1] mirror_valid

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CountW-1:0] cfg_data
);

    logic              alt_mode_reg;
    logic [CountW-1:0] tick_step_reg;

    logic              in_valid_reg, in_valid_next;
    item_t             in_item_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_result_reg;
    result_t           core_result;

    logic              advance;   // result register can take a new word
    logic              load_in;
    logic              step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_mode_reg  <= 1'b0;
            tick_step_reg <= TICK_STEP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALT_MODE:  alt_mode_reg  <= cfg_data[0];
                CFG_TICK_STEP: tick_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;
    assign step     = in_valid_reg && advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load_in)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_item_reg.opcode  <= op_t'(s_tuser);
            in_item_reg.address <= s_tdata[AddrW-1:0];
            in_item_reg.wr_data <= s_tdata[AddrW+DataW-1:AddrW];
        end
        if (step)
            out_result_reg <= core_result;
    end

    bsim_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .alt_mode  (alt_mode_reg),
        .tick_step (tick_step_reg),
        .result    (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_result_reg.mirror_vertical,
                       out_result_reg.bank_value,
                       out_result_reg.bank_slot,
                       out_result_reg.irq_fire};
    assign m_tuser  = {out_result_reg.mirror_valid, out_result_reg.bank_valid};

endmodule

>>> rtl/core/bsim_checker.sv
// Port-level checks for the mapper top level, bound to every instance.
module bsim_checker import bsim_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // nothing comes out in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a word is a bank update, a mirroring update, an IRQ, or nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]) && !(m_tdata[0] && (m_tuser != 2'b00)))
        else $error("result word carries more than one kind");

    // slot in range, unused fields zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[4:1] <= SLOT_LAST)
        else $error("bank slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[12:1] == 12'd0)
        else $error("bank fields set without bank update");

endmodule

bind bank_switch_scanline_irq_mapper_top bsim_checker u_bsim_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
